/* rtl/pretrigger_ring_capture_top_macros.svh */
// Assertion macros used by the checker file of the capture block.
`ifndef PRETRIGGER_RING_CAPTURE_TOP_MACROS_SVH
`define PRETRIGGER_RING_CAPTURE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prc check failed");

// Next-cycle implication, disabled during reset.
`define PRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prc check failed");

`endif

/* rtl/prc_pkg.sv */
package prc_pkg;

  // Default values of the top-level parameters.
  localparam int CHANNELS_DEF    = 8;
  localparam int RING_DEPTH_DEF  = 262144;
  localparam int MAX_SECONDS_DEF = 60;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths.
  localparam int CH_FIELD_W = 3;
  localparam int SECS_W     = 6;
  localparam int RATE_W     = 18;
  localparam int LEN_W      = 19;
  localparam int NCH_CFG_W  = 4;
  localparam int DECAY_W    = 23;
  localparam int CFG_W      = 23;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_FRAMES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SECONDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY      = 3'd4;

  // Configuration reset values.
  localparam logic [RATE_W-1:0]    RATE_RST    = 18'd48000;
  localparam logic [LEN_W-1:0]     LEN_RST     = 19'd262144;
  localparam logic [NCH_CFG_W-1:0] NCH_RST     = 4'd2;
  localparam logic [SECS_W-1:0]    DEF_SEC_RST = 6'd5;
  localparam logic [DECAY_W-1:0]   DECAY_RST   = 23'd838861;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_CAPTURE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_METER   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_PEAK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_IDLE = 2'd2
  } status_t;

  // Job handed from the control stage to the result sequencer.
  typedef struct packed {
    logic    load;
    kind_t   kind;
    status_t status;
    logic    eoc;
  } job_t;

endpackage

/* rtl/pretrigger_ring_capture_top.sv */
// Always-recording multichannel audio ring with lookback capture and peak meter.
// A push is taken every cycle and writes one lane of the frame row at the head;
// pushes keep flowing while results are delivered. A capture request, or a read
// with no open capture, gets one status result; else a read or meter tick gives
// one result per active channel, one per cycle unless stalled, and the next
// non-push item is taken in the cycle its last result transfers. The window
// start and length are set in the accepting cycle, so items may follow back to
// back. After reset the ring is swept to zero one frame row per cycle; no item
// is taken until the sweep ends; configuration writes are taken throughout.
module pretrigger_ring_capture_top
  import prc_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_SECONDS = MAX_SECONDS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int FRAME_W = $clog2(RING_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [CH_FIELD_W-1:0]         channel,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [SECS_W-1:0]             seconds,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [1:0]                    status,
  output logic [CH_FIELD_W-1:0]         out_channel,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [FRAME_W-1:0]            window_frames,
  output logic                          last,
  output logic                          end_of_capture,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PK_W  = SAMPLE_BITS - 1;

  logic                                 ready;
  logic                                 job_free;
  job_t                                 job;
  logic [FRAME_W-1:0]                   job_win;
  logic [CH_IW-1:0]                     job_nlast;
  logic [CHANNELS-1:0][PK_W-1:0]        peak_snap;
  logic                                 wr_en;
  logic [PTR_W-1:0]                     wr_addr;
  logic [CH_IW-1:0]                     wr_lane;
  logic [SAMPLE_BITS-1:0]               wr_data;
  logic                                 rd_en;
  logic [PTR_W-1:0]                     rd_addr;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] rd_data;

  prc_ring #(
    .CHANNELS    (CHANNELS),
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ready   (ready),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_lane (wr_lane),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prc_ctrl #(
    .CHANNELS    (CHANNELS),
    .RING_DEPTH  (RING_DEPTH),
    .MAX_SECONDS (MAX_SECONDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ready     (ready),
    .job_free  (job_free),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .channel   (channel),
    .sample    (sample),
    .seconds   (seconds),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (job),
    .job_win   (job_win),
    .job_nlast (job_nlast),
    .peak_snap (peak_snap),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_lane   (wr_lane),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  prc_emit #(
    .CHANNELS    (CHANNELS),
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .job            (job),
    .job_win        (job_win),
    .job_nlast      (job_nlast),
    .peak_snap      (peak_snap),
    .rd_data        (rd_data),
    .job_free       (job_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .status         (status),
    .out_channel    (out_channel),
    .value          (value),
    .window_frames  (window_frames),
    .last           (last),
    .end_of_capture (end_of_capture)
  );

endmodule

/* rtl/prc_ring.sv */
module prc_ring
  import prc_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int PTR_W = $clog2(RING_DEPTH),
  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  ready,
  input  logic                                  wr_en,
  input  logic [PTR_W-1:0]                      wr_addr,
  input  logic [CH_IW-1:0]                      wr_lane,
  input  logic [SAMPLE_BITS-1:0]                wr_data,
  input  logic                                  rd_en,
  input  logic [PTR_W-1:0]                      rd_addr,
  output logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  rd_data
);

  // One row holds one frame: a lane per channel.
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] mem [RING_DEPTH];

  logic             clearing;
  logic [PTR_W-1:0] clr_idx;

  // Sweep every row to zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == PTR_W'(RING_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ready = !clearing;

  // Write one lane or clear one row; registered read of a whole row.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/prc_ctrl.sv */
module prc_ctrl
  import prc_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_SECONDS = MAX_SECONDS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int PTR_W   = $clog2(RING_DEPTH),
  localparam int FRAME_W = $clog2(RING_DEPTH + 1),
  localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int PK_W    = SAMPLE_BITS - 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ready,
  input  logic                           job_free,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     func,
  input  logic [CH_FIELD_W-1:0]          channel,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic [SECS_W-1:0]              seconds,
  // configuration
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  // job to the result sequencer
  output job_t                           job,
  output logic [FRAME_W-1:0]             job_win,
  output logic [CH_IW-1:0]               job_nlast,
  output logic [CHANNELS-1:0][PK_W-1:0]  peak_snap,
  // ring memory
  output logic                           wr_en,
  output logic [PTR_W-1:0]               wr_addr,
  output logic [CH_IW-1:0]               wr_lane,
  output logic [SAMPLE_BITS-1:0]         wr_data,
  output logic                           rd_en,
  output logic [PTR_W-1:0]               rd_addr
);

  localparam int NCH_W  = $clog2(CHANNELS + 1);
  localparam int NC_CW  = (NCH_W > NCH_CFG_W) ? NCH_W : NCH_CFG_W;
  localparam int CC_W   = (NCH_W > CH_FIELD_W) ? NCH_W : CH_FIELD_W;
  localparam int LEN_CW = (FRAME_W > LEN_W) ? FRAME_W : LEN_W;
  localparam int PROD_W = SECS_W + RATE_W;
  localparam int CMP_W  = (FRAME_W > PROD_W) ? FRAME_W : PROD_W;
  localparam int MS_W   = $clog2(MAX_SECONDS + 1);
  localparam int SC_W   = (MS_W > SECS_W) ? MS_W : SECS_W;
  localparam int DEC_W  = (PK_W > DECAY_W) ? PK_W : DECAY_W;
  localparam int RP_W   = FRAME_W + 1;

  // Configuration registers
  logic [RATE_W-1:0]    frame_rate;
  logic [LEN_W-1:0]     ring_frames;
  logic [NCH_CFG_W-1:0] num_channels;
  logic [SECS_W-1:0]    default_seconds;
  logic [DECAY_W-1:0]   peak_decay;

  // Block state
  logic [PTR_W-1:0]            head_pos;
  logic [FRAME_W-1:0]          recorded_frames;
  logic                        capture_busy;
  logic [PTR_W-1:0]            read_pos;
  logic [FRAME_W-1:0]          frames_left;
  logic [CHANNELS-1:0][PK_W-1:0] peak_hold;

  func_t              fn;
  logic               acc;
  logic [NCH_W-1:0]   nch_eff;
  logic [FRAME_W-1:0] len_eff;
  logic               push_ok;
  logic               frame_end;
  logic [CH_IW-1:0]   lane;
  logic [SAMPLE_BITS-1:0] mag_full;
  logic [PK_W-1:0]    mag;
  logic [FRAME_W-1:0] head_inc;
  logic [PTR_W-1:0]   head_adv;
  logic [FRAME_W-1:0] read_inc;
  logic [PTR_W-1:0]   read_adv;
  logic [SECS_W-1:0]  secs_sel;
  logic [SECS_W-1:0]  secs_clamp;
  logic [PROD_W-1:0]  prod;
  logic [CMP_W-1:0]   f_len;
  logic [CMP_W-1:0]   f_rec;
  logic [FRAME_W-1:0] f_win;
  logic [RP_W-1:0]    rp_full;

  assign fn  = func_t'(func);
  assign in_stall = !ready || ((fn != FUNC_PUSH) && !job_free);
  assign acc = in_valid && !in_stall;

  // Clamp channel count and ring length between one and the built sizes.
  always_comb begin
    if (num_channels == '0) begin
      nch_eff = NCH_W'(1);
    end else if (NC_CW'(num_channels) > NC_CW'(CHANNELS)) begin
      nch_eff = NCH_W'(CHANNELS);
    end else begin
      nch_eff = NCH_W'(num_channels);
    end
    if (ring_frames == '0) begin
      len_eff = FRAME_W'(1);
    end else if (LEN_CW'(ring_frames) > LEN_CW'(RING_DEPTH)) begin
      len_eff = FRAME_W'(RING_DEPTH);
    end else begin
      len_eff = FRAME_W'(ring_frames);
    end
  end

  // Push: lane select, frame end and saturated magnitude.
  always_comb begin
    push_ok   = CC_W'(channel) < CC_W'(nch_eff);
    frame_end = push_ok && (CC_W'(channel) == CC_W'(nch_eff) - CC_W'(1));
    lane      = CH_IW'(channel);
    mag_full  = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    if (mag_full[SAMPLE_BITS-1]) begin
      mag = '1;
    end else begin
      mag = mag_full[PK_W-1:0];
    end
  end

  // Pointer advance with wrap at the ring length.
  always_comb begin
    head_inc = FRAME_W'(head_pos) + FRAME_W'(1);
    head_adv = (head_inc >= len_eff) ? '0 : PTR_W'(head_inc);
    read_inc = FRAME_W'(read_pos) + FRAME_W'(1);
    read_adv = (read_inc >= len_eff) ? '0 : PTR_W'(read_inc);
  end

  // Capture window: seconds times rate, clamped to length and recorded frames.
  always_comb begin
    if (seconds != '0) begin
      secs_sel = seconds;
    end else if (default_seconds != '0) begin
      secs_sel = default_seconds;
    end else begin
      secs_sel = SECS_W'(1);
    end
    if (SC_W'(secs_sel) > SC_W'(MAX_SECONDS)) begin
      secs_clamp = SECS_W'(MAX_SECONDS);
    end else begin
      secs_clamp = secs_sel;
    end
    prod  = PROD_W'(secs_clamp) * PROD_W'(frame_rate);
    f_len = (CMP_W'(prod) > CMP_W'(len_eff)) ? CMP_W'(len_eff) : CMP_W'(prod);
    f_rec = (f_len > CMP_W'(recorded_frames)) ? CMP_W'(recorded_frames) : f_len;
    f_win = FRAME_W'(f_rec);
    if (RP_W'(head_pos) >= RP_W'(f_win)) begin
      rp_full = RP_W'(head_pos) - RP_W'(f_win);
    end else begin
      rp_full = RP_W'(head_pos) + RP_W'(len_eff) - RP_W'(f_win);
    end
  end

  // Job and memory requests for the accepted item.
  always_comb begin
    job        = '0;
    job.kind   = KIND_STATUS;
    job.status = ST_OK;
    job_win    = '0;
    job_nlast  = CH_IW'(nch_eff - NCH_W'(1));
    peak_snap  = peak_hold;
    wr_en      = 1'b0;
    wr_addr    = head_pos;
    wr_lane    = lane;
    wr_data    = sample;
    rd_en      = 1'b0;
    rd_addr    = read_pos;
    if (acc) begin
      unique case (fn)
        FUNC_PUSH: begin
          wr_en = push_ok;
        end
        FUNC_CAPTURE: begin
          job.load = 1'b1;
          if (capture_busy) begin
            job.status = ST_BUSY;
          end else begin
            job_win = f_win;
          end
        end
        FUNC_READ: begin
          job.load = 1'b1;
          if (!capture_busy) begin
            job.status = ST_IDLE;
          end else begin
            job.kind = KIND_SAMPLE;
            job.eoc  = (frames_left <= FRAME_W'(1));
            job_win  = frames_left;
            rd_en    = 1'b1;
          end
        end
        FUNC_METER: begin
          job.load = 1'b1;
          job.kind = KIND_PEAK;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate      <= RATE_RST;
      ring_frames     <= LEN_RST;
      num_channels    <= NCH_RST;
      default_seconds <= DEF_SEC_RST;
      peak_decay      <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_RATE:      frame_rate      <= cfg_data[RATE_W-1:0];
        REG_RING_FRAMES:     ring_frames     <= cfg_data[LEN_W-1:0];
        REG_NUM_CHANNELS:    num_channels    <= cfg_data[NCH_CFG_W-1:0];
        REG_DEFAULT_SECONDS: default_seconds <= cfg_data[SECS_W-1:0];
        REG_PEAK_DECAY:      peak_decay      <= cfg_data[DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update head, capture window and peaks on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_pos        <= '0;
      recorded_frames <= '0;
      capture_busy    <= 1'b0;
      read_pos        <= '0;
      frames_left     <= '0;
      peak_hold       <= '0;
    end else if (acc) begin
      unique case (fn)
        FUNC_PUSH: begin
          if (push_ok && (mag > peak_hold[lane])) begin
            peak_hold[lane] <= mag;
          end
          if (frame_end) begin
            head_pos <= head_adv;
            if (recorded_frames < FRAME_W'(RING_DEPTH)) begin
              recorded_frames <= recorded_frames + FRAME_W'(1);
            end
          end
        end
        FUNC_CAPTURE: begin
          if (!capture_busy && (f_win != '0)) begin
            read_pos     <= PTR_W'(rp_full);
            frames_left  <= f_win;
            capture_busy <= 1'b1;
          end
        end
        FUNC_READ: begin
          if (capture_busy) begin
            read_pos <= read_adv;
            if (frames_left != '0) begin
              frames_left <= frames_left - FRAME_W'(1);
            end
            if (frames_left <= FRAME_W'(1)) begin
              capture_busy <= 1'b0;
            end
          end
        end
        FUNC_METER: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (DEC_W'(peak_hold[c]) > DEC_W'(peak_decay)) begin
              peak_hold[c] <= peak_hold[c] - PK_W'(peak_decay);
            end else begin
              peak_hold[c] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/prc_emit.sv */
module prc_emit
  import prc_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int FRAME_W = $clog2(RING_DEPTH + 1),
  localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int PK_W    = SAMPLE_BITS - 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  job_t                                  job,
  input  logic [FRAME_W-1:0]                    job_win,
  input  logic [CH_IW-1:0]                      job_nlast,
  input  logic [CHANNELS-1:0][PK_W-1:0]         peak_snap,
  input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  rd_data,
  output logic                                  job_free,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            kind,
  output logic [1:0]                            status,
  output logic [CH_FIELD_W-1:0]                 out_channel,
  output logic signed [SAMPLE_BITS-1:0]         value,
  output logic [FRAME_W-1:0]                    window_frames,
  output logic                                  last,
  output logic                                  end_of_capture
);

  logic                          b_valid;
  kind_t                         b_kind;
  status_t                       b_status;
  logic                          b_eoc;
  logic [FRAME_W-1:0]            b_win;
  logic [CH_IW-1:0]              b_nlast;
  logic [CH_IW-1:0]              b_lane;
  logic [CHANNELS-1:0][PK_W-1:0] snap;
  logic                          b_last;
  logic                          out_acc;
  logic [CH_IW+CH_FIELD_W-1:0]   lane_ext;

  assign b_last   = (b_kind == KIND_STATUS) || (b_lane == b_nlast);
  assign out_acc  = b_valid && !out_stall;
  assign job_free = !b_valid || (out_acc && b_last);

  // Hold the job until its last result transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (job.load) begin
      b_valid <= 1'b1;
    end else if (out_acc && b_last) begin
      b_valid <= 1'b0;
    end
  end

  // Load job fields, step the lane after each transfer.
  always_ff @(posedge clk) begin
    if (job.load) begin
      b_kind   <= job.kind;
      b_status <= job.status;
      b_eoc    <= job.eoc;
      b_win    <= job_win;
      b_nlast  <= job_nlast;
      b_lane   <= '0;
      if (job.kind == KIND_PEAK) begin
        snap <= peak_snap;
      end
    end else if (out_acc && !b_last) begin
      b_lane <= b_lane + 1'b1;
    end
  end

  // Drive the result fields from the held job.
  always_comb begin
    lane_ext       = {{CH_FIELD_W{1'b0}}, b_lane};
    out_valid      = b_valid;
    kind           = b_kind;
    status         = b_status;
    window_frames  = b_win;
    last           = b_last;
    end_of_capture = b_eoc;
    out_channel    = lane_ext[CH_FIELD_W-1:0];
    unique case (b_kind)
      KIND_SAMPLE: value = rd_data[b_lane];
      KIND_PEAK:   value = {1'b0, snap[b_lane]};
      default:     value = '0;
    endcase
  end

endmodule

/* rtl/prc_checker.sv */
`include "pretrigger_ring_capture_top_macros.svh"

module prc_checker
  import prc_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int FRAME_W = $clog2(RING_DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    kind,
  input logic [1:0]                    status,
  input logic signed [SAMPLE_BITS-1:0] value,
  input logic [FRAME_W-1:0]            window_frames,
  input logic                          last,
  input logic                          end_of_capture
);

  // A stalled result stays offered and unchanged.
  `PRC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value) && $stable(kind))

  // A status answer is always a single result.
  `PRC_ASSERT_NOW(a_status_last, clk, rst, out_valid && kind == KIND_STATUS, last)

  // End of capture only marks samples of the final window frame.
  `PRC_ASSERT_NOW(a_eoc_sample, clk, rst, out_valid && end_of_capture, kind == KIND_SAMPLE && window_frames <= 1)

  // Peaks are non-negative and carry no status or window.
  `PRC_ASSERT_NOW(a_peak_fields, clk, rst, out_valid && kind == KIND_PEAK, status == ST_OK && window_frames == 0 && !value[SAMPLE_BITS-1])

endmodule

bind pretrigger_ring_capture_top prc_checker #(
  .RING_DEPTH  (RING_DEPTH),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_prc_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import prc_pkg::*;

  localparam int CHANNELS       = CHANNELS_DEF;
  localparam int RING_DEPTH     = RING_DEPTH_DEF;
  localparam int MAX_SECONDS    = MAX_SECONDS_DEF;
  localparam int PEAK_MAX       = 2 ** (SAMPLE_BITS_DEF - 1) - 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int ITEMS_PER_PHASE = 28;
  // the ring sweep after reset holds off every item until it ends
  localparam int WATCHDOG_LIMIT = 4 * RING_DEPTH + 5000;

  typedef struct {
    kind_t              kind;
    status_t            status;
    logic [2:0]         chan;
    logic signed [23:0] value;
    logic [18:0]        win;
    logic               last;
    logic               eoc;
  } ring_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  func_t              in_func;
  logic [2:0]         in_channel;
  logic signed [23:0] in_sample;
  logic [5:0]         in_seconds;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic [1:0]         status;
  logic [2:0]         out_channel;
  logic signed [23:0] value;
  logic [18:0]        window_frames;
  logic               last;
  logic               end_of_capture;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [22:0]        cfg_data;

  // predicted block state
  logic signed [23:0] ring_mem [int unsigned];
  logic [17:0]        head_pos_q;
  logic [18:0]        rec_frames_q;
  logic               capture_busy_q;
  logic [17:0]        rd_pos_q;
  logic [18:0]        frames_left_q;
  logic [22:0]        peak_q [CHANNELS];
  logic [17:0]        rate_q;
  logic [18:0]        len_q;
  logic [3:0]         nch_q;
  logic [5:0]         defsec_q;
  logic [22:0]        decay_q;

  ring_result_t awaited[$];
  ring_result_t seen_exp;
  bit           no_gaps;
  int           n_items;
  int           n_results;
  int           n_windows;
  int           n_peaks;
  int           n_errors;
  int           quiet_cycles;

  pretrigger_ring_capture_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (in_func),
    .channel        (in_channel),
    .sample         (in_sample),
    .seconds        (in_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .status         (status),
    .out_channel    (out_channel),
    .value          (value),
    .window_frames  (window_frames),
    .last           (last),
    .end_of_capture (end_of_capture),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned active_chans();
    if (nch_q == 0) return 1;
    if (nch_q > CHANNELS) return CHANNELS;
    return nch_q;
  endfunction

  function automatic int unsigned ring_len();
    if (len_q == 0) return 1;
    if (len_q > RING_DEPTH) return RING_DEPTH;
    return len_q;
  endfunction

  function automatic logic [17:0] next_pos(int unsigned p, int unsigned len);
    return (p + 1 >= len) ? 18'd0 : 18'(p + 1);
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return -24'sd1;
      3: return 24'sd0;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] pick_secs();
    case ($urandom_range(0, 5))
      0: return 6'd0;
      1: return 6'($urandom_range(58, 63));
      default: return 6'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic void add_result(kind_t k, status_t st, int unsigned ch,
                                     logic signed [23:0] v, int unsigned win,
                                     bit lst, bit eoc);
    ring_result_t r;
    r.kind   = k;
    r.status = st;
    r.chan   = 3'(ch);
    r.value  = v;
    r.win    = 19'(win);
    r.last   = lst;
    r.eoc    = eoc;
    awaited.push_back(r);
  endfunction

  // Advance the predicted state by one item and queue the results it causes.
  function automatic void ring_predict(func_t f, logic [2:0] ch,
                                       logic signed [23:0] smp, logic [5:0] secs);
    int unsigned       nch;
    int unsigned       len;
    int unsigned       s;
    int unsigned       fl;
    int unsigned       mag;
    int unsigned       key;
    int signed         sv;
    longint unsigned   frames;
    bit                eoc;
    logic signed [23:0] rv;
    nch = active_chans();
    len = ring_len();
    case (f)
      FUNC_PUSH: begin
        if (ch < nch) begin
          ring_mem[int'(ch) * RING_DEPTH + head_pos_q] = smp;
          sv  = smp;
          mag = (sv < 0) ? -sv : sv;
          if (mag > PEAK_MAX) mag = PEAK_MAX;
          if (mag > peak_q[ch]) peak_q[ch] = 23'(mag);
          // last active channel closes the frame
          if (ch == nch - 1) begin
            head_pos_q = next_pos(head_pos_q, len);
            if (rec_frames_q < RING_DEPTH) rec_frames_q = rec_frames_q + 1;
          end
        end
      end
      FUNC_CAPTURE: begin
        if (capture_busy_q) begin
          add_result(KIND_STATUS, ST_BUSY, 0, 0, 0, 1, 0);
        end else begin
          s = secs;
          if (s == 0) s = (defsec_q != 0) ? defsec_q : 1;
          if (s > MAX_SECONDS) s = MAX_SECONDS;
          frames = longint'(s) * rate_q;
          if (frames > len) frames = len;
          if (frames > rec_frames_q) frames = rec_frames_q;
          fl = int'(frames);
          if (fl > 0) begin
            rd_pos_q = (head_pos_q >= fl) ? 18'(head_pos_q - fl)
                                          : 18'(head_pos_q + len - fl);
            frames_left_q  = 19'(fl);
            capture_busy_q = 1'b1;
            n_windows++;
          end
          add_result(KIND_STATUS, ST_OK, 0, 0, fl, 1, 0);
        end
      end
      FUNC_READ: begin
        if (!capture_busy_q) begin
          add_result(KIND_STATUS, ST_IDLE, 0, 0, 0, 1, 0);
        end else begin
          eoc = (frames_left_q <= 1);
          for (int unsigned c = 0; c < nch; c++) begin
            key = c * RING_DEPTH + rd_pos_q;
            rv  = ring_mem.exists(key) ? ring_mem[key] : 24'sd0;
            add_result(KIND_SAMPLE, ST_OK, c, rv, frames_left_q, c == nch - 1, eoc);
          end
          rd_pos_q = next_pos(rd_pos_q, len);
          if (frames_left_q > 0) frames_left_q = frames_left_q - 1;
          if (frames_left_q == 0) capture_busy_q = 1'b0;
        end
      end
      default: begin
        for (int unsigned c = 0; c < nch; c++) begin
          add_result(KIND_PEAK, ST_OK, c, $signed({1'b0, peak_q[c]}), 0, c == nch - 1, 0);
          n_peaks++;
        end
        // decay every channel, active or not
        for (int c = 0; c < CHANNELS; c++)
          peak_q[c] = (peak_q[c] > decay_q) ? peak_q[c] - decay_q : 23'd0;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %0d at %0t: %s got %0d expected %0d",
             n_errors, $time, what, got, want);
  endtask

  // Present one item, hold it until the transfer, then predict.
  task automatic send_item(func_t f, logic [2:0] ch, logic signed [23:0] smp,
                           logic [5:0] secs);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_func    <= f;
    in_channel <= ch;
    in_sample  <= smp;
    in_seconds <= secs;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (f != FUNC_PUSH || ch < active_chans()) n_items++;
    ring_predict(f, ch, smp, secs);
  endtask

  task automatic push(logic [2:0] ch, logic signed [23:0] smp);
    send_item(FUNC_PUSH, ch, smp, 6'($urandom_range(0, 63)));
  endtask

  task automatic push_frame();
    for (int unsigned c = 0; c < active_chans(); c++) push(3'(c), pick_sample());
  endtask

  task automatic capture(logic [5:0] secs);
    send_item(FUNC_CAPTURE, 3'($urandom_range(0, 7)), pick_sample(), secs);
  endtask

  task automatic read_frame();
    send_item(FUNC_READ, 3'($urandom_range(0, 7)), pick_sample(),
              6'($urandom_range(0, 63)));
  endtask

  task automatic read_peaks();
    send_item(FUNC_METER, 3'($urandom_range(0, 7)), pick_sample(),
              6'($urandom_range(0, 63)));
  endtask

  // Drop valid and hold off until every predicted result has transferred.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 23'(data);
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_RATE:      rate_q   = 18'(data);
      REG_RING_FRAMES:     len_q    = 19'(data);
      REG_NUM_CHANNELS:    nch_q    = 4'(data);
      REG_DEFAULT_SECONDS: defsec_q = 6'(data);
      REG_PEAK_DECAY:      decay_q  = 23'(data);
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned rate, int unsigned len, int unsigned nch,
                          int unsigned defsec, int unsigned decay);
    wait_idle();
    write_reg(REG_FRAME_RATE, rate);
    write_reg(REG_RING_FRAMES, len);
    write_reg(REG_NUM_CHANNELS, nch);
    write_reg(REG_DEFAULT_SECONDS, defsec);
    write_reg(REG_PEAK_DECAY, decay);
  endtask

  // Reset values: empty ring, idle read, saturation, busy refusal, full replay.
  task automatic test_basic_items();
    read_frame();
    capture(6'd0);
    read_peaks();
    push(3'd0, 24'sh7FFFFF);
    push(3'd1, 24'sh800000);
    push(3'd7, 24'sd123);
    push(3'd0, -24'sd1);
    push(3'd1, 24'sd1);
    push(3'd0, 24'sd0);
    push(3'd1, -24'sd8388607);
    capture(6'd63);
    capture(6'd1);
    read_frame();
    read_peaks();
    read_frame();
    read_frame();
    read_frame();
    read_peaks();
  endtask

  // Zero rate, zero default, clamped length and channel count, full decay.
  task automatic test_register_limits();
    set_regs(0, RING_DEPTH, 2, 5, DECAY_RST);
    push_frame();
    capture(6'd4);
    read_frame();
    set_regs(1, RING_DEPTH, 2, 0, DECAY_RST);
    capture(6'd0);
    read_frame();
    set_regs(1, 0, 0, 5, 0);
    push(3'd0, 24'sh400000);
    push(3'd1, 24'sh123456);
    capture(6'd5);
    read_frame();
    read_peaks();
    set_regs(1, 0, 12, 5, 23'h7FFFFF);
    push_frame();
    read_peaks();
    read_peaks();
  endtask

  // Shrink the ring under a running capture; the read pointer above the
  // new length is used once more and then wraps.
  task automatic test_ring_shrink();
    set_regs(1, 16, 1, 3, 1000);
    repeat (12) push_frame();
    capture(6'd3);
    read_frame();
    wait_idle();
    write_reg(REG_RING_FRAMES, 4);
    read_frame();
    read_frame();
    repeat (3) push_frame();
    capture(6'd0);
    repeat (3) read_frame();
  endtask

  // Mostly whole frames, captures and replays with random content, some noise.
  task automatic test_random_traffic();
    int  stop_at;
    int  r;
    int  n;
    bit  paused;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_regs(1, 4, 8, 60, 0);
        1: set_regs(2, 1, 1, 1, 23'h7FFFFF);
        2: set_regs($urandom_range(1, 3), $urandom_range(2, 40), $urandom_range(1, 8),
                    $urandom_range(1, 60), $urandom_range(0, 23'h7FFFFF));
        3: set_regs(192000, RING_DEPTH, 3, 60, $urandom_range(0, 2000000));
        default: set_regs($urandom_range(1, 192000), $urandom_range(1, 64),
                          $urandom_range(1, 8), $urandom_range(1, 60), $urandom);
      endcase
      stop_at = n_items + ITEMS_PER_PHASE;
      paused  = 1'b0;
      while (n_items < stop_at) begin
        no_gaps = ((n_items / 15) % 4) == 3;
        // hold the sender once per phase until everything has come back
        if (!paused && n_items >= stop_at - ITEMS_PER_PHASE / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
          push_frame();
        end else if (r < 55) begin
          capture(pick_secs());
        end else if (r < 80) begin
          if (!capture_busy_q || $urandom_range(0, 4) == 0)
            n = 1;
          else if ($urandom_range(0, 2) == 0)
            n = (frames_left_q > 10) ? 10 : frames_left_q;
          else
            n = $urandom_range(1, 3);
          repeat (n) read_frame();
        end else if (r < 88) begin
          read_peaks();
        end else begin
          send_item(func_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    pick_sample(), 6'($urandom_range(0, 63)));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: draw a stall length before each result, then take it.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = draw_gap();
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each transferred result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result, kind", kind, -1);
      end else begin
        seen_exp = awaited.pop_front();
        if (kind !== seen_exp.kind) report_mismatch("kind", kind, seen_exp.kind);
        if (status !== seen_exp.status)
          report_mismatch("status", status, seen_exp.status);
        if (out_channel !== seen_exp.chan)
          report_mismatch("out_channel", out_channel, seen_exp.chan);
        if (value !== seen_exp.value)
          report_mismatch("value", $signed(value), seen_exp.value);
        if (window_frames !== seen_exp.win)
          report_mismatch("window_frames", window_frames, seen_exp.win);
        if (last !== seen_exp.last) report_mismatch("last", last, seen_exp.last);
        if (end_of_capture !== seen_exp.eoc)
          report_mismatch("end_of_capture", end_of_capture, seen_exp.eoc);
      end
    end
  end

  // Stop the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, awaited.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_func    = FUNC_PUSH;
    in_channel = '0;
    in_sample  = '0;
    in_seconds = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    no_gaps    = 1'b0;
    head_pos_q     = '0;
    rec_frames_q   = '0;
    capture_busy_q = 1'b0;
    rd_pos_q       = '0;
    frames_left_q  = '0;
    for (int c = 0; c < CHANNELS; c++) peak_q[c] = '0;
    rate_q   = RATE_RST;
    len_q    = LEN_RST;
    nch_q    = NCH_RST;
    defsec_q = DEF_SEC_RST;
    decay_q  = DECAY_RST;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_basic_items();
    test_register_limits();
    test_ring_shrink();
    test_random_traffic();
    wait_idle();

    $display("covered %0d input transfers and %0d checked results", n_items, n_results);
    $display("%0d capture windows opened, %0d peak readings, %0d mismatches",
             n_windows, n_peaks, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
